// ===== hw/rtl/tat_pkg.sv =====
// ---------------------------------------------------------------------------
// tat_pkg: shared types and constants for the tile animation table
// Table sizing, command codes and the layouts of the two RAM words.
// ---------------------------------------------------------------------------
package tat_pkg;

    // Table capacity; tile indexes are 8 bits, so no more than 256 are reachable
    localparam int MAX_TILES = 256;
    localparam int EFF_TILES = (MAX_TILES < 256) ? MAX_TILES : 256;
    localparam int ADDR_W    = (EFF_TILES > 1) ? $clog2(EFF_TILES) : 1;
    localparam int CNT_W     = 9;

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Countdown floor
    localparam logic [15:0] CD_MIN = 16'h8000;

    // Loaded tile properties
    typedef struct packed {
        logic        anim;
        logic [14:0] delay;
        logic [15:0] succ;
    } t_prop;

    // Running state of one entry (own animated flag kept alongside)
    typedef struct packed {
        logic        anim;
        logic [7:0]  shown;
        logic [15:0] cd;
        logic [15:0] pend;
    } t_entry;

    localparam int PROP_W  = $bits(t_prop);
    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== hw/rtl/tile_animation_table.sv =====
// ---------------------------------------------------------------------------
// tile_animation_table: per-tile animation state for a tile set
// Loads tile properties, steps every tile in use on a tick, answers frame
// queries. Properties and running state live in two RAMs.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | i_valid / o_ready    | command, tile_index, animated_flag,
//          |           |                      | frame_delay, next_tile
//  out     | output    | o_valid / i_ready    | current_frame, index_error
//  cfg     | input     | i_cfg_we             | i_cfg_data (tiles_in_use)
//
//  Load: written to both RAMs on acceptance. Query: state read, then the output
//  register, plus any wait for it. Tick: per tile in use, a state read and, where needed,
//  a property read of the shown frame and a property read of the successor, in turn,
//  as the single read port of each RAM sets.
//  Reset is synchronous, active low, and clears control state only; RAM
//  contents are undefined until loaded. A stalled output word holds; loads and
//  ticks are still accepted behind it, a query waits for the slot.
// ---------------------------------------------------------------------------
module tile_animation_table
    import tat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    // input words
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_tile_index,
    input  logic               i_animated_flag,
    input  logic [14:0]        i_frame_delay,
    input  logic signed [15:0] i_next_tile,
    // output words
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_current_frame,
    output logic               o_index_error
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_CUR   = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_ADV   = 3'd4;
    localparam logic [2:0] ST_QUERY = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_tiles_in_use;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [7:0]        r_shown, n_shown;
    logic [15:0]       r_cd, n_cd;
    logic [15:0]       r_pend, n_pend;
    logic              r_qerr, n_qerr;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_frame, n_out_frame;
    logic              r_out_err, n_out_err;

    logic              in_acc;
    logic [CNT_W-1:0]  eff_count;
    logic              tick_last;
    logic              pend_ok;
    logic              step;

    logic              prop_we, prop_re;
    logic [ADDR_W-1:0] prop_waddr, prop_raddr;
    t_prop             prop_wdata, prop_rd;
    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    t_entry            st_wdata, st_rd;

    // RAMs: loaded properties and running entry state
    tat_ram #(.WIDTH(PROP_W), .DEPTH(EFF_TILES)) u_prop_ram (
        .i_clk   (i_clk),
        .i_we    (prop_we),
        .i_waddr (prop_waddr),
        .i_wdata (prop_wdata),
        .i_re    (prop_re),
        .i_raddr (prop_raddr),
        .o_rdata (prop_rd)
    );

    tat_ram #(.WIDTH(ENTRY_W), .DEPTH(EFF_TILES)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rd)
    );

    // Handshakes and derived counts
    assign o_ready   = (r_state == ST_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign eff_count = (r_tiles_in_use > CNT_W'(EFF_TILES)) ? CNT_W'(EFF_TILES)
                                                            : r_tiles_in_use;
    assign tick_last = ((CNT_W'(r_idx) + CNT_W'(1)) == eff_count);
    assign pend_ok   = !r_pend[15] && (r_pend[14:0] < 15'(eff_count));

    assign o_valid         = r_out_valid;
    assign o_current_frame = r_out_frame;
    assign o_index_error   = r_out_err;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_shown     = r_shown;
        n_cd        = r_cd;
        n_pend      = r_pend;
        n_qerr      = r_qerr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_frame = r_out_frame;
        n_out_err   = r_out_err;
        step        = 1'b0;
        prop_we     = 1'b0;
        prop_waddr  = i_tile_index[ADDR_W-1:0];
        prop_wdata  = '{anim: i_animated_flag, delay: i_frame_delay, succ: i_next_tile};
        prop_re     = 1'b0;
        prop_raddr  = r_shown[ADDR_W-1:0];
        st_we       = 1'b0;
        st_waddr    = r_idx;
        st_wdata    = '{anim: i_animated_flag, shown: i_tile_index,
                        cd: {1'b0, i_frame_delay}, pend: i_next_tile};
        st_re       = 1'b0;
        st_raddr    = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_command)
                        CMD_LOAD: begin
                            if ({1'b0, i_tile_index} < CNT_W'(EFF_TILES)) begin
                                prop_we  = 1'b1;
                                st_we    = 1'b1;
                                st_waddr = i_tile_index[ADDR_W-1:0];
                            end
                        end
                        CMD_TICK: begin
                            n_idx = '0;
                            if (eff_count != '0) begin
                                n_state = ST_FETCH;
                            end
                        end
                        CMD_QUERY: begin
                            st_re    = 1'b1;
                            st_raddr = i_tile_index[ADDR_W-1:0];
                            n_qerr   = !({1'b0, i_tile_index} < eff_count);
                            n_state  = ST_QUERY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                st_re   = 1'b1;
                n_state = ST_CUR;
            end
            ST_CUR: begin
                // latch the entry, decrement with saturation at the floor
                n_shown = st_rd.shown;
                n_pend  = st_rd.pend;
                n_cd    = (st_rd.cd == CD_MIN) ? st_rd.cd : (st_rd.cd - 16'd1);
                if (st_rd.anim && ({1'b0, st_rd.shown} < CNT_W'(EFF_TILES))) begin
                    prop_re    = 1'b1;
                    prop_raddr = st_rd.shown[ADDR_W-1:0];
                    n_state    = ST_CHK;
                end else begin
                    step = 1'b1;
                end
            end
            ST_CHK: begin
                if (!prop_rd.anim) begin
                    step = 1'b1;
                end else if (r_cd[15] && pend_ok) begin
                    prop_re    = 1'b1;
                    prop_raddr = r_pend[ADDR_W-1:0];
                    n_state    = ST_ADV;
                end else begin
                    st_we    = 1'b1;
                    st_wdata = '{anim: 1'b1, shown: r_shown, cd: r_cd, pend: r_pend};
                    step     = 1'b1;
                end
            end
            ST_ADV: begin
                // advance to the successor and reload from its properties
                st_we    = 1'b1;
                st_wdata = '{anim: 1'b1, shown: r_pend[7:0], cd: {1'b0, prop_rd.delay},
                             pend: prop_rd.succ};
                step     = 1'b1;
            end
            ST_QUERY: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_frame = r_qerr ? 8'd0 : st_rd.shown;
                    n_out_err   = r_qerr;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // move on to the next tile or finish the tick
        if (step) begin
            if (tick_last) begin
                n_state = ST_IDLE;
            end else begin
                n_idx   = r_idx + ADDR_W'(1);
                n_state = ST_FETCH;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_tiles_in_use <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tiles_in_use <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_shown     <= n_shown;
        r_cd        <= n_cd;
        r_pend      <= n_pend;
        r_qerr      <= n_qerr;
        r_out_frame <= n_out_frame;
        r_out_err   <= n_out_err;
    end

    // Checks
    a_state_wr_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> ((in_acc && (i_command == CMD_LOAD)) || (r_state == ST_CHK)
                   || (r_state == ST_ADV)))
        else $error("state RAM written outside a load or tick update");

    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_QUERY))
        else $error("output word raised without a query");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (CNT_W'(r_idx) < eff_count))
        else $error("tick index beyond tiles in use");

    a_adv_after_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV) |-> ($past(r_state) == ST_CHK))
        else $error("successor reload without a check");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_state == ST_IDLE) && !r_out_valid))
        else $error("not idle after reset");

endmodule

// ===== hw/rtl/tat_ram.sv =====
// ---------------------------------------------------------------------------
// tat_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ---------------------------------------------------------------------------
module tat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
